// ===== rtl/imhdk_pkg.sv =====
// Shared constants, codes and types of the indexed min-heap.
// Used by the controller, the top level and the testbench; depends on nothing.
package imhdk_pkg;

  localparam int CAPACITY  = 1024;
  localparam int KEY_SPACE = 1024;
  localparam int PRIO_BITS = 16;
  localparam int KEY_W     = 10;
  localparam int POS_W     = $clog2(CAPACITY);
  localparam int CNT_W     = POS_W + 1;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_LOWERED  = 3'd1;
  localparam logic [2:0] ST_IGNORED  = 3'd2;
  localparam logic [2:0] ST_POPPED   = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_POP    = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic [PRIO_BITS-1:0] prio;
  } slot_t;

  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] pos;
  } map_t;

  typedef struct packed {
    logic             we;
    logic [POS_W-1:0] waddr;
    slot_t            wdata;
    logic [POS_W-1:0] raddr;
  } heap_req_t;

  typedef struct packed {
    logic             we;
    logic [KEY_W-1:0] waddr;
    map_t             wdata;
    logic [KEY_W-1:0] raddr;
  } map_req_t;

endpackage

// ===== rtl/imhdk_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Standalone; no package needed.
module imhdk_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 26
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/imhdk_ctrl.sv =====
// Sequencer of the indexed min-heap: map clearing, insert, decrease-key, pop and sifts.
// Depends on imhdk_pkg; drives the heap and position map RAMs.
module imhdk_ctrl import imhdk_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 kind,
  input  logic [KEY_W-1:0]     item_key,
  input  logic [PRIO_BITS-1:0] item_priority,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           status,
  output logic [KEY_W-1:0]     popped_key,
  output logic [PRIO_BITS-1:0] popped_priority,
  output logic [CNT_W-1:0]     occupancy,
  output heap_req_t            heap_req,
  input  slot_t                heap_q,
  output map_req_t             map_req,
  input  map_t                 map_q
);
  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_IMAP   = 4'd2;
  localparam logic [3:0] S_DRD    = 4'd3;
  localparam logic [3:0] S_UP     = 4'd4;
  localparam logic [3:0] S_UPCMP  = 4'd5;
  localparam logic [3:0] S_FIN    = 4'd6;
  localparam logic [3:0] S_PROOT  = 4'd7;
  localparam logic [3:0] S_PLAST  = 4'd8;
  localparam logic [3:0] S_DN     = 4'd9;
  localparam logic [3:0] S_DNL    = 4'd10;
  localparam logic [3:0] S_DNR    = 4'd11;
  localparam logic [3:0] S_OUT    = 4'd12;

  logic [3:0]           state;
  logic [KEY_W-1:0]     clr_addr;
  logic [POS_W-1:0]     pos;
  logic [CNT_W-1:0]     cnt;
  slot_t                mov;
  slot_t                lft;
  logic [KEY_W-1:0]     key_r;
  logic [PRIO_BITS-1:0] prio_r;
  logic [2:0]           st_r;
  logic [KEY_W-1:0]     pk;
  logic [PRIO_BITS-1:0] pp;

  logic [POS_W-1:0] parent;
  logic [CNT_W-1:0] lidx;
  logic [CNT_W:0]   ridx;
  logic [CNT_W-1:0] last;
  logic             has_right;
  slot_t            child;
  logic [POS_W-1:0] cidx;
  logic             move_dn;

  assign parent    = (pos - POS_W'(1)) >> 1;
  assign lidx      = {pos, 1'b1};
  assign ridx      = {1'b0, pos, 1'b0} + (CNT_W+1)'(2);
  assign last      = cnt - CNT_W'(1);
  assign has_right = ridx < {1'b0, cnt};

  always_comb begin
    if (state == S_DNR && heap_q.prio < lft.prio) begin
      child = heap_q;
      cidx  = ridx[POS_W-1:0];
    end else if (state == S_DNR) begin
      child = lft;
      cidx  = lidx[POS_W-1:0];
    end else begin
      child = heap_q;
      cidx  = lidx[POS_W-1:0];
    end
    move_dn = child.prio < mov.prio;
  end

  always_comb begin
    heap_req = '0;
    map_req  = '0;
    map_req.raddr = item_key;
    unique case (state)
      S_CLR: begin
        map_req.we    = 1'b1;
        map_req.waddr = clr_addr;
      end
      S_IDLE: heap_req.raddr = '0;
      S_IMAP: heap_req.raddr = map_q.pos;
      S_UP: heap_req.raddr = parent;
      S_UPCMP: begin
        if (mov.prio < heap_q.prio) begin
          heap_req.we    = 1'b1;
          heap_req.waddr = pos;
          heap_req.wdata = heap_q;
          map_req.we     = 1'b1;
          map_req.waddr  = heap_q.key;
          map_req.wdata  = '{valid: 1'b1, pos: pos};
        end
      end
      S_FIN: begin
        heap_req.we    = 1'b1;
        heap_req.waddr = pos;
        heap_req.wdata = mov;
        map_req.we     = 1'b1;
        map_req.waddr  = mov.key;
        map_req.wdata  = '{valid: 1'b1, pos: pos};
      end
      S_PROOT: begin
        heap_req.raddr = last[POS_W-1:0];
        map_req.we     = 1'b1;
        map_req.waddr  = heap_q.key;
      end
      S_DN: heap_req.raddr = lidx[POS_W-1:0];
      S_DNL, S_DNR: begin
        if (state == S_DNL) begin
          heap_req.raddr = ridx[POS_W-1:0];
        end
        if ((state == S_DNR || !has_right) && move_dn) begin
          heap_req.we    = 1'b1;
          heap_req.waddr = pos;
          heap_req.wdata = child;
          map_req.we     = 1'b1;
          map_req.waddr  = child.key;
          map_req.wdata  = '{valid: 1'b1, pos: pos};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_addr <= '0;
      cnt      <= '0;
    end else begin
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + KEY_W'(1);
          if (clr_addr == KEY_W'(KEY_SPACE - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            key_r  <= item_key;
            prio_r <= item_priority;
            pk     <= '0;
            pp     <= '0;
            if (kind == KIND_POP) begin
              if (cnt == '0) begin
                st_r  <= ST_EMPTY;
                state <= S_OUT;
              end else begin
                st_r  <= ST_POPPED;
                state <= S_PROOT;
              end
            end else if ({1'b0, item_key} >= (KEY_W+1)'(KEY_SPACE)) begin
              st_r  <= ST_IGNORED;
              state <= S_OUT;
            end else begin
              state <= S_IMAP;
            end
          end
        end
        S_IMAP: begin
          if (map_q.valid) begin
            pos <= map_q.pos;
            if ({1'b0, map_q.pos} < cnt) begin
              state <= S_DRD;
            end else begin
              st_r  <= ST_IGNORED;
              state <= S_OUT;
            end
          end else if (cnt >= CNT_W'(CAPACITY)) begin
            st_r  <= ST_FULL;
            state <= S_OUT;
          end else begin
            pos   <= cnt[POS_W-1:0];
            cnt   <= cnt + CNT_W'(1);
            mov   <= '{key: key_r, prio: prio_r};
            st_r  <= ST_INSERTED;
            state <= S_UP;
          end
        end
        S_DRD: begin
          if (prio_r < heap_q.prio) begin
            mov   <= '{key: key_r, prio: prio_r};
            st_r  <= ST_LOWERED;
            state <= S_UP;
          end else begin
            st_r  <= ST_IGNORED;
            state <= S_OUT;
          end
        end
        S_UP: begin
          state <= (pos == '0) ? S_FIN : S_UPCMP;
        end
        S_UPCMP: begin
          if (mov.prio < heap_q.prio) begin
            pos   <= parent;
            state <= S_UP;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: state <= S_OUT;
        S_PROOT: begin
          pk    <= heap_q.key;
          pp    <= heap_q.prio;
          cnt   <= last;
          state <= (last == '0) ? S_OUT : S_PLAST;
        end
        S_PLAST: begin
          mov   <= heap_q;
          pos   <= '0;
          state <= S_DN;
        end
        S_DN: begin
          state <= (lidx < cnt) ? S_DNL : S_FIN;
        end
        S_DNL: begin
          lft <= heap_q;
          if (has_right) begin
            state <= S_DNR;
          end else if (move_dn) begin
            pos   <= cidx;
            state <= S_DN;
          end else begin
            state <= S_FIN;
          end
        end
        S_DNR: begin
          if (move_dn) begin
            pos   <= cidx;
            state <= S_DN;
          end else begin
            state <= S_FIN;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_stall        = state != S_IDLE;
  assign out_valid       = state == S_OUT;
  assign status          = st_r;
  assign popped_key      = pk;
  assign popped_priority = pp;
  assign occupancy       = cnt;
endmodule

// ===== rtl/indexed_min_heap_decrease_key.sv =====
// Indexed binary min-heap with decrease-key, top level.
// Depends on imhdk_pkg, imhdk_ram and imhdk_ctrl.
//
// Input channel (in_valid/in_stall) carries one item: kind selects insert or
// decrease-key (key and priority) or pop of the minimum. The output channel
// (out_valid/out_stall) returns one item per input item: status, the popped
// key and priority, and the occupancy after the operation.
// One item is handled at a time. The time to a result grows with the number of
// levels that an insert or decrease-key climbs or that a pop descends, as the
// sift walks the heap RAM level by level, reading the parent on the way up
// and the children on the way down. The next item can be taken in the cycle
// after the result is accepted. After reset the position map is cleared in a
// pass over all its entries during which in_stall stays high. A result waits in
// its output register while out_stall is high, and no new item is taken until
// it has been accepted.
module indexed_min_heap_decrease_key import imhdk_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 kind,
  input  logic [KEY_W-1:0]     item_key,
  input  logic [PRIO_BITS-1:0] item_priority,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           status,
  output logic [KEY_W-1:0]     popped_key,
  output logic [PRIO_BITS-1:0] popped_priority,
  output logic [CNT_W-1:0]     occupancy
);
  heap_req_t heap_req;
  map_req_t  map_req;
  slot_t     heap_q;
  map_t      map_q;

  imhdk_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .kind, .item_key, .item_priority,
    .out_valid, .out_stall, .status, .popped_key, .popped_priority, .occupancy,
    .heap_req, .heap_q, .map_req, .map_q
  );

  imhdk_ram #(.DEPTH(CAPACITY), .WIDTH($bits(slot_t))) u_heap (
    .clk, .we(heap_req.we), .waddr(heap_req.waddr), .wdata(heap_req.wdata),
    .raddr(heap_req.raddr), .rdata(heap_q)
  );

  imhdk_ram #(.DEPTH(KEY_SPACE), .WIDTH($bits(map_t))) u_map (
    .clk, .we(map_req.we), .waddr(map_req.waddr), .wdata(map_req.wdata),
    .raddr(map_req.raddr), .rdata(map_q)
  );

`ifndef SYNTH
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("item accepted while result pending");
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= CNT_W'(CAPACITY)) else $error("occupancy beyond capacity");
  a_pop_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_POPPED) |-> (popped_key == '0 && popped_priority == '0))
    else $error("popped fields set on a non-pop result");
  a_pop_occ: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_EMPTY) |-> occupancy == '0)
    else $error("empty error with entries present");
`endif
endmodule

// ===== test/tb_indexed_min_heap_decrease_key.sv =====
// Testbench of the indexed min-heap with decrease-key: directed cases, then random
// insert, decrease-key and pop traffic with input idling and output back-pressure.
// Depends on imhdk_pkg and the indexed_min_heap_decrease_key RTL.
module tb_indexed_min_heap_decrease_key import imhdk_pkg::*;;

  typedef struct {
    logic [2:0]           st;
    logic [KEY_W-1:0]     pkey;
    logic [PRIO_BITS-1:0] pprio;
    logic [CNT_W-1:0]     occ;
  } heap_result_t;

  typedef struct {
    logic [KEY_W-1:0]     key;
    logic [PRIO_BITS-1:0] prio;
  } entry_t;

  localparam int DEEP_FILL = 256;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic kind = KIND_INSERT;
  logic [KEY_W-1:0] item_key = '0;
  logic [PRIO_BITS-1:0] item_priority = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] status;
  logic [KEY_W-1:0] popped_key;
  logic [PRIO_BITS-1:0] popped_priority;
  logic [CNT_W-1:0] occupancy;

  indexed_min_heap_decrease_key dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  entry_t heap_model[CAPACITY];
  logic map_valid[KEY_SPACE];
  int unsigned map_pos[KEY_SPACE];
  int unsigned heap_size = 0;
  heap_result_t expected_results[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_receiver = 0;
  int quiet_cycles = 0;
  int pops_done = 0;
  int lowers_done = 0;

  function automatic void put_entry(int unsigned p, entry_t e);
    heap_model[p] = e;
    map_valid[e.key] = 1'b1;
    map_pos[e.key] = p;
  endfunction

  function automatic void swap_entries(int unsigned a, int unsigned b);
    entry_t ea, eb;
    ea = heap_model[a];
    eb = heap_model[b];
    put_entry(a, eb);
    put_entry(b, ea);
  endfunction

  function automatic void sift_up(int unsigned p);
    int unsigned parent;
    while (p > 0) begin
      parent = (p - 1) / 2;
      if (heap_model[p].prio < heap_model[parent].prio) begin
        swap_entries(p, parent);
        p = parent;
      end else begin
        break;
      end
    end
  endfunction

  function automatic void sift_down(int unsigned p);
    int unsigned best, l, r;
    forever begin
      best = p;
      l = 2 * p + 1;
      r = 2 * p + 2;
      if (l < heap_size && heap_model[l].prio < heap_model[best].prio) best = l;
      if (r < heap_size && heap_model[r].prio < heap_model[best].prio) best = r;
      if (best == p) break;
      swap_entries(p, best);
      p = best;
    end
  endfunction

  function automatic heap_result_t predict_heap_op(logic k, logic [KEY_W-1:0] key,
                                                   logic [PRIO_BITS-1:0] prio);
    heap_result_t r;
    entry_t top, e;
    r.pkey = '0;
    r.pprio = '0;
    if (k == KIND_POP) begin
      if (heap_size == 0) begin
        r.st = ST_EMPTY;
      end else begin
        top = heap_model[0];
        r.pkey = top.key;
        r.pprio = top.prio;
        if (heap_size > 1) put_entry(0, heap_model[heap_size - 1]);
        heap_size--;
        map_valid[top.key] = 1'b0;
        if (heap_size > 0) sift_down(0);
        r.st = ST_POPPED;
      end
    end else if (map_valid[key]) begin
      if (map_pos[key] < heap_size && prio < heap_model[map_pos[key]].prio) begin
        heap_model[map_pos[key]].prio = prio;
        sift_up(map_pos[key]);
        r.st = ST_LOWERED;
      end else begin
        r.st = ST_IGNORED;
      end
    end else if (heap_size >= CAPACITY) begin
      r.st = ST_FULL;
    end else begin
      e.key = key;
      e.prio = prio;
      put_entry(heap_size, e);
      heap_size++;
      sift_up(heap_size - 1);
      r.st = ST_INSERTED;
    end
    r.occ = CNT_W'(heap_size);
    return r;
  endfunction

  task automatic send_item(logic k, logic [KEY_W-1:0] key, logic [PRIO_BITS-1:0] prio);
    heap_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    item_key <= key;
    item_priority <= prio;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = predict_heap_op(k, key, prio);
    expected_results.push_back(r);
    items_sent++;
    if (r.st == ST_POPPED) pops_done++;
    if (r.st == ST_LOWERED) lowers_done++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst) out_stall <= hold_receiver || ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    heap_result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("unexpected result, status %0d", status);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (status !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, status);
          errors++;
        end
        if (popped_key !== want.pkey) begin
          $error("popped_key: expected %0d, got %0d", want.pkey, popped_key);
          errors++;
        end
        if (popped_priority !== want.pprio) begin
          $error("popped_priority: expected %0d, got %0d", want.pprio, popped_priority);
          errors++;
        end
        if (occupancy !== want.occ) begin
          $error("occupancy: expected %0d, got %0d", want.occ, occupancy);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("indexed_min_heap_decrease_key verification failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(KIND_POP, 10'd0, 16'd0);
    send_item(KIND_INSERT, 10'd0, 16'hFFFF);
    send_item(KIND_INSERT, 10'd1023, 16'h0000);
    send_item(KIND_INSERT, 10'd5, 16'h0100);
    send_item(KIND_INSERT, 10'd6, 16'h0100);
    send_item(KIND_INSERT, 10'd7, 16'h0100);
    send_item(KIND_INSERT, 10'd5, 16'h0100);
    send_item(KIND_INSERT, 10'd5, 16'h0200);
    send_item(KIND_INSERT, 10'd0, 16'h0001);
    send_item(KIND_INSERT, 10'd7, 16'h0000);
    send_item(KIND_INSERT, 10'h2AA, 16'hAAAA);
    send_item(KIND_INSERT, 10'h155, 16'h5555);
    repeat (9) send_item(KIND_POP, 10'h3FF, 16'hFFFF);
  endtask

  task automatic test_random_mix(int n, int key_range);
    int unsigned pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 45)
        send_item(KIND_INSERT, KEY_W'($urandom_range(key_range)), PRIO_BITS'($urandom));
      else if (pick < 65 && heap_size > 0)
        send_item(KIND_INSERT, heap_model[$urandom_range(heap_size - 1)].key,
                  PRIO_BITS'($urandom_range(65535)));
      else
        send_item(KIND_POP, KEY_W'($urandom), PRIO_BITS'($urandom));
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_receiver = 1;
        repeat (300) @(posedge clk);
        hold_receiver = 0;
      end
      test_random_mix(20, 63);
    join
    drain_results();
  endtask

  task automatic test_deep_heap();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int k = 0; k < KEY_SPACE && heap_size < DEEP_FILL; k++)
      if (!map_valid[k])
        send_item(KIND_INSERT, KEY_W'(k), PRIO_BITS'($urandom_range(65535)));
    send_item(KIND_INSERT, heap_model[0].key, 16'd0);
    while (heap_size > 0) send_item(KIND_POP, 10'd0, 16'd0);
    send_item(KIND_POP, 10'd0, 16'd0);
    drain_results();
  endtask

  initial begin
    for (int k = 0; k < KEY_SPACE; k++) map_valid[k] = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 12;
    recv_stall_pct = 71;
    test_directed();
    test_random_mix(150, 1023);
    drain_results();
    send_idle_pct = 71;
    recv_stall_pct = 12;
    test_random_mix(150, 63);
    test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_mix(230, 255);
    drain_results();
    test_deep_heap();
    $display("Sent %0d items (%0d pops, %0d priority decreases), checked %0d results,",
             items_sent, pops_done, lowers_done, results_seen);
    $display("including a held-off receiver and a heap grown to %0d entries and emptied.",
             DEEP_FILL);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("indexed_min_heap_decrease_key verification clean");
    end else begin
      $display("indexed_min_heap_decrease_key verification failed");
    end
    $finish;
  end
endmodule
